// ===== rtl/core/ptt_pkg.sv =====
// Shared types and constants of the periodic task timer table.
package ptt_pkg;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_DISPATCH = 2'd2;
   localparam logic [1:0] OP_DELETE   = 2'd3;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_BAD_SLOT = 3'd2;
   localparam logic [2:0] ST_RUN      = 3'd3;
   localparam logic [2:0] ST_NONE     = 3'd4;

   localparam logic [4:0] RESULT_LIMIT = 5'd16;
   localparam logic [7:0] PENDING_MAX  = 8'hFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] task_tag;
      logic [31:0] start_delay;
      logic [31:0] run_period;
      logic [3:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] run_tag;
      logic [3:0]  run_task_id;
      logic [4:0]  task_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [3:0]  id;
      logic [31:0] delay;
      logic [31:0] period;
      logic [7:0]  pending;
   } slot_type;

   typedef struct packed {
      logic keep;
      logic emit;
   } upd_ctl_type;

endpackage

// ===== rtl/core/periodic_task_timer_table_unit.sv =====
// Top level of the periodic task timer table: command control and table walk.
//
//   Channel  Ports                       Direction  Transaction
//   request  start, busy, req_data       in         taken when start and not busy
//   result   rsp_strobe, rsp_data        out        valid for one cycle per strobe
//
// Add and a rejected delete end on acceptance; the result follows on the next cycle.
// Tick and dispatch walk every occupied slot, and a delete the slots from its index
// up, one slot per cycle, through the registered RAM read; a walk of an empty table
// ends without reading a slot. The final result follows on the next cycle.
// Dispatch results appear during the walk, the final one at its end.
// Reset clears the occupancy count; slot contents are only read once written.
// The receiver cannot stall results, so busy alone paces the requester.
module periodic_task_timer_table_unit
   import ptt_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SW = $bits(slot_type);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TASKS);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WALK = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] del_ff, del_in;
   logic        dv_ff, dv_in;
   logic [4:0]  n_ff, n_in;
   logic        hold_vld_ff, hold_vld_in;
   rsp_type     hold_ff, hold_in;
   logic [3:0]  rm_id_ff, rm_id_in;
   logic [1:0]  op_ff, op_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   slot_type      wr_slot;
   logic [SW-1:0] rd_bits;
   slot_type      rd_slot;
   slot_type      new_slot;
   upd_ctl_type   upd_ctl;
   logic          accept;
   logic [CW-1:0] del_now;
   logic [CW+3:0] idx_ext;
   logic [CW+3:0] count_ext;

   function automatic logic [4:0] to_count5(input logic [CW-1:0] v);
      logic [CW+4:0] ext;
      ext = {5'd0, v};
      return ext[4:0];
   endfunction

   function automatic logic [3:0] to_id4(input logic [CW-1:0] v);
      logic [CW+3:0] ext;
      ext = {4'd0, v};
      return ext[3:0];
   endfunction

   ptt_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_TASKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_slot = slot_type'(rd_bits);

   ptt_upd u_upd (
      .operation  (op_ff),
      .slot_in    (rd_slot),
      .limit_hit  (n_ff >= RESULT_LIMIT),
      .first_slot (del_ff == '0),
      .slot_out   (new_slot),
      .ctl        (upd_ctl)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign del_now   = upd_ctl.keep ? del_ff : del_ff + CW'(1);
   assign idx_ext   = {{CW{1'b0}}, req_data.slot_index};
   assign count_ext = {4'd0, count_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      del_in        = del_ff;
      dv_in         = 1'b0;
      n_in          = n_ff;
      hold_vld_in   = hold_vld_ff;
      hold_in       = hold_ff;
      rm_id_in      = rm_id_ff;
      op_in         = op_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = wr_ptr_ff[AW-1:0];
      wr_slot       = new_slot;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_data.operation;
               case (req_data.operation)
                  OP_ADD: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff < MAX_COUNT) begin
                        wr_en           = 1'b1;
                        wr_addr         = count_ff[AW-1:0];
                        wr_slot.tag     = req_data.task_tag;
                        wr_slot.id      = to_id4(count_ff);
                        wr_slot.delay   = req_data.start_delay;
                        wr_slot.period  = req_data.run_period;
                        wr_slot.pending = 8'd0;
                        count_in        = count_ff + CW'(1);
                        rsp_in = '{ST_DONE, 16'd0, to_id4(count_ff),
                                   to_count5(count_ff + CW'(1)), 1'b1};
                     end else begin
                        rsp_in = '{ST_FULL, 16'd0, 4'd0, to_count5(count_ff), 1'b1};
                     end
                  end
                  OP_DELETE: begin
                     if (idx_ext >= count_ext) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = '{ST_BAD_SLOT, 16'd0, 4'd0, to_count5(count_ff), 1'b1};
                     end else begin
                        state_in    = S_WALK;
                        rd_ptr_in   = idx_ext[CW-1:0];
                        wr_ptr_in   = idx_ext[CW-1:0];
                        del_in      = '0;
                        n_in        = 5'd0;
                        hold_vld_in = 1'b0;
                     end
                  end
                  default: begin
                     state_in    = S_WALK;
                     rd_ptr_in   = '0;
                     wr_ptr_in   = '0;
                     del_in      = '0;
                     n_in        = 5'd0;
                     hold_vld_in = 1'b0;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (rd_ptr_ff < count_ff) begin
               dv_in     = 1'b1;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (dv_ff) begin
               del_in = del_now;
               if (upd_ctl.keep) begin
                  wr_en     = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end else begin
                  rm_id_in = rd_slot.id;
               end
               if (upd_ctl.emit) begin
                  n_in        = n_ff + 5'd1;
                  hold_vld_in = 1'b1;
                  hold_in = '{ST_RUN, rd_slot.tag, rd_slot.id,
                              to_count5(count_ff - del_now), 1'b0};
                  if (hold_vld_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = hold_ff;
                  end
               end
            end else if (rd_ptr_ff >= count_ff) begin
               state_in      = S_IDLE;
               count_in      = count_ff - del_ff;
               rsp_strobe_in = 1'b1;
               hold_vld_in   = 1'b0;
               case (op_ff)
                  OP_DISPATCH: begin
                     if (hold_vld_ff) begin
                        rsp_in      = hold_ff;
                        rsp_in.last = 1'b1;
                     end else begin
                        rsp_in = '{ST_NONE, 16'd0, 4'd0, to_count5(count_ff), 1'b1};
                     end
                  end
                  OP_DELETE: begin
                     rsp_in = '{ST_DONE, 16'd0, rm_id_ff,
                                to_count5(count_ff - del_ff), 1'b1};
                  end
                  default: begin
                     rsp_in = '{ST_DONE, 16'd0, 4'd0, to_count5(count_ff), 1'b1};
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         del_ff        <= '0;
         dv_ff         <= 1'b0;
         n_ff          <= 5'd0;
         hold_vld_ff   <= 1'b0;
         op_ff         <= OP_ADD;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         del_ff        <= del_in;
         dv_ff         <= dv_in;
         n_ff          <= n_in;
         hold_vld_ff   <= hold_vld_in;
         op_ff         <= op_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      hold_ff  <= hold_in;
      rm_id_ff <= rm_id_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (wr_ptr_ff <= rd_ptr_ff))
      else $error("Walk write pointer passed the read pointer.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("Occupancy count exceeds the table depth.");

   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RESULT_LIMIT)
      else $error("Dispatch produced more results than allowed.");

   a_data_in_walk: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> (state_ff == S_WALK))
      else $error("Slot read data arrived outside a walk.");

endmodule

// ===== rtl/core/ptt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ptt_upd.sv =====
// Per-slot update logic applied to each slot read during a table walk.
module ptt_upd
   import ptt_pkg::*;
(
   input  logic [1:0]  operation,
   input  slot_type    slot_in,
   input  logic        limit_hit,
   input  logic        first_slot,
   output slot_type    slot_out,
   output upd_ctl_type ctl
);

   always_comb begin
      slot_out = slot_in;
      ctl.keep = 1'b1;
      ctl.emit = 1'b0;
      case (operation)
         OP_TICK: begin
            if (slot_in.delay != 32'd0) begin
               slot_out.delay = slot_in.delay - 32'd1;
            end else begin
               slot_out.delay = slot_in.period;
               if (slot_in.pending != PENDING_MAX) begin
                  slot_out.pending = slot_in.pending + 8'd1;
               end
            end
         end
         OP_DISPATCH: begin
            if ((slot_in.pending != 8'd0) && !limit_hit) begin
               slot_out.pending = slot_in.pending - 8'd1;
               ctl.emit = 1'b1;
               ctl.keep = (slot_in.period != 32'd0);
            end
         end
         OP_DELETE: begin
            ctl.keep = !first_slot;
         end
         default: begin
         end
      endcase
   end

endmodule
